// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted
`define AOC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds while reset is asserted
`define AOC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/aoc_pkg.sv =====
`timescale 1ns / 1ps
package aoc_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS    = 12;
  localparam int GUARD_BITS   = 8;
  localparam int ANG_BITS     = 20;

  // Iteration counts of the pipelined units
  localparam int CORDIC_STEPS = 21;
  localparam int SQA_N        = 29;
  localparam int SQB_N        = 28;
  localparam int DIV_N        = 29;

  localparam logic [21:0] PI_Q      = 22'd3294199;
  localparam logic [21:0] HALF_PI_Q = 22'd1647099;
  localparam logic [15:0] W_ONE     = 16'd32768;

  // One CORDIC vector: abscissa, ordinate, accumulated angle
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [22:0] z;
  } cordic_t;

  // atan(2^-i) with ANG_BITS fraction bits
  function automatic logic [19:0] atan_q(input int unsigned i);
    logic [19:0] v;
    case (i)
      0:       v = 20'd823550;
      1:       v = 20'd486170;
      2:       v = 20'd256879;
      3:       v = 20'd130396;
      4:       v = 20'd65451;
      5:       v = 20'd32757;
      6:       v = 20'd16383;
      7:       v = 20'd8192;
      8:       v = 20'd4096;
      9:       v = 20'd2048;
      10:      v = 20'd1024;
      11:      v = 20'd512;
      12:      v = 20'd256;
      13:      v = 20'd128;
      14:      v = 20'd64;
      15:      v = 20'd32;
      16:      v = 20'd16;
      17:      v = 20'd8;
      18:      v = 20'd4;
      19:      v = 20'd2;
      20:      v = 20'd1;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/aoc_cordic.sv =====
`timescale 1ns / 1ps
module aoc_cordic import aoc_pkg::*; (
  input  logic    clk_i,
  input  logic    en_i,
  input  cordic_t vec_i,
  output cordic_t vec_o
);

  cordic_t stg_q [CORDIC_STEPS];

  // One vectoring rotation per register stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    cordic_t src;
    cordic_t nxt;

    if (i == 0) begin : g_first
      assign src = vec_i;
    end else begin : g_next
      assign src = stg_q[i-1];
    end

    always_comb begin
      nxt = src;
      if (src.y > 0) begin
        nxt.x = src.x + (src.y >>> i);
        nxt.y = src.y - (src.x >>> i);
        nxt.z = src.z + 23'(atan_q(i));
      end else begin
        nxt.x = src.x - (src.y >>> i);
        nxt.y = src.y + (src.x >>> i);
        nxt.z = src.z - 23'(atan_q(i));
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[i] <= nxt;
      end
    end
  end

  assign vec_o = stg_q[CORDIC_STEPS-1];

endmodule

// ===== sv/asymmetric_overlap_competition_core.sv =====
// Circle overlap competition core. Each input transfer carries two circles (self and other,
// signed Q12.12 centers, unsigned Q8.12 radii); the result transfer gives the area shared by
// both discs (unsigned Q20.12) and a competition value that blends an asymmetric share (the
// full overlap when the self radius is larger, half at equal radii, else zero) with half the
// overlap, weighted by the asym_weight register (Q1.15, values above one act as one;
// written through cfg_we_i / cfg_wdata_i while the core is idle, a user rule the core does
// not enforce). Discs that are apart or touching give zero, and a disc inside the other gives
// pi times the smaller radius squared. The core, a 125-stage pipeline with two digit-by-digit
// square roots (29 and 28 stages), a 29-stage restoring divider for the chord foot and two
// 21-stage CORDIC arctangent lanes, takes one transfer per clock unless the result side stalls.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module asymmetric_overlap_competition_core import aoc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [23:0] self_x_i,
  input  logic signed [23:0] self_y_i,
  input  logic [19:0]        self_radius_i,
  input  logic signed [23:0] other_x_i,
  input  logic signed [23:0] other_y_i,
  input  logic [19:0]        other_radius_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        overlap_area_o,
  output logic [31:0]        competition_o
);

  // Per-item context riding along the pipeline
  typedef struct packed {
    logic               vld;
    logic               eq_r;
    logic               r0_gt;
    logic               apart;
    logic               contain;
    logic [19:0]        r0;
    logic [19:0]        r1;
    logic [19:0]        m;
    logic [23:0]        adx;
    logic [23:0]        ady;
    logic [20:0]        sum;
    logic [19:0]        diff;
    logic [47:0]        dxsq;
    logic [47:0]        dysq;
    logic [41:0]        sumsq;
    logic [39:0]        diffsq;
    logic [39:0]        r0sq;
    logic [39:0]        r1sq;
    logic [39:0]        msq;
    logic [57:0]        d2e;
    logic [28:0]        de;
    logic signed [59:0] num;
    logic               qsign;
    logic [58:0]        mag;
    logic               ovf;
    logic [27:0]        qm;
    logic signed [29:0] d0;
    logic signed [30:0] d1;
    logic [55:0]        qsq;
    logic [55:0]        hrad;
    logic [27:0]        he;
    logic [60:0]        t;
    logic               neg0;
    logic               neg1;
    logic [30:0]        x0;
    logic [30:0]        x1;
    logic [21:0]        a0;
    logic [21:0]        a1;
    logic [41:0]        pal;
    logic [41:0]        pah;
    logic [41:0]        pbl;
    logic [41:0]        pbh;
    logic [63:0]        sa;
    logic [63:0]        sb;
    logic [63:0]        s;
    logic [31:0]        area;
    logic [47:0]        pw;
    logic [46:0]        pv;
    logic [31:0]        comp;
  } ctx_t;

  typedef struct packed {
    logic [SQA_N+1:0]   rem;
    logic [SQA_N-1:0]   root;
    logic [2*SQA_N-1:0] rad;
  } sqa_t;

  typedef struct packed {
    logic [SQB_N+1:0]   rem;
    logic [SQB_N-1:0]   root;
    logic [2*SQB_N-1:0] rad;
  } sqb_t;

  typedef struct packed {
    logic [29:0] rem;
    logic [28:0] q;
    logic [28:0] low;
  } div_t;

  logic        adv;
  logic [15:0] w_q;
  logic [15:0] wc;

  ctx_t p0_d, p0_q, p1_d, p1_q, p2_d, p2_q;
  ctx_t p3_d, p3_q, p4_d, p4_q, p5_d, p5_q;
  ctx_t p6_d, p6_q, p7_d, p7_q, p8_d, p8_q;
  ctx_t p9_d, p9_q, p10_d, p10_q, p11_d, p11_q;
  ctx_t p12_d, p12_q, p13_d, p13_q, p14_d, p14_q;
  ctx_t p15_d, p15_q, p16_d, p16_q, out_d, out_q;

  sqa_t sqa_in;
  sqa_t sqa_q   [SQA_N];
  ctx_t sqa_c_q [SQA_N];
  div_t div_in;
  div_t div_q   [DIV_N];
  ctx_t div_c_q [DIV_N];
  sqb_t sqb_in;
  sqb_t sqb_q   [SQB_N];
  ctx_t sqb_c_q [SQB_N];
  ctx_t cd_q    [CORDIC_STEPS];

  cordic_t c0_in, c0_out, c1_in, c1_out;

  // Global pipeline advance: the whole pipe holds while a result waits
  assign adv        = !(out_q.vld && out_stall_i);
  assign in_stall_o = !adv;

  // Weight register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= '0;
    end else if (cfg_we_i) begin
      w_q <= cfg_wdata_i;
    end
  end

  assign wc = (w_q > W_ONE) ? W_ONE : w_q;

  // Final angle: clamp to [0, pi/2], mirror for a negative abscissa
  function automatic logic [21:0] ang_fix(input logic signed [22:0] z, input logic neg);
    logic [21:0] zc;
    if (z < 0) begin
      zc = '0;
    end else if (z > $signed({1'b0, HALF_PI_Q})) begin
      zc = HALF_PI_Q;
    end else begin
      zc = z[21:0];
    end
    return neg ? PI_Q - zc : zc;
  endfunction

  // Stage 0: center deltas, radius sum and difference
  always_comb begin
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    p0_d      = '0;
    p0_d.vld  = in_valid_i;
    dx        = {self_x_i[23], self_x_i} - {other_x_i[23], other_x_i};
    dy        = {self_y_i[23], self_y_i} - {other_y_i[23], other_y_i};
    p0_d.adx  = dx[24] ? 24'(-dx) : dx[23:0];
    p0_d.ady  = dy[24] ? 24'(-dy) : dy[23:0];
    p0_d.r0   = self_radius_i;
    p0_d.r1   = other_radius_i;
    p0_d.sum  = 21'(self_radius_i) + 21'(other_radius_i);
    p0_d.diff = (self_radius_i > other_radius_i) ? self_radius_i - other_radius_i
                                                 : other_radius_i - self_radius_i;
    p0_d.m    = (self_radius_i < other_radius_i) ? self_radius_i : other_radius_i;
    p0_d.eq_r = (self_radius_i == other_radius_i);
    p0_d.r0_gt = (self_radius_i > other_radius_i);
  end

  // Stage 1: exact squares
  always_comb begin
    p1_d        = p0_q;
    p1_d.dxsq   = p0_q.adx * p0_q.adx;
    p1_d.dysq   = p0_q.ady * p0_q.ady;
    p1_d.sumsq  = p0_q.sum * p0_q.sum;
    p1_d.diffsq = p0_q.diff * p0_q.diff;
    p1_d.r0sq   = p0_q.r0 * p0_q.r0;
    p1_d.r1sq   = p0_q.r1 * p0_q.r1;
    p1_d.msq    = p0_q.m * p0_q.m;
  end

  // Stage 2: squared distance and the apart / containment tests
  always_comb begin
    logic [48:0] d2;
    p2_d         = p1_q;
    d2           = 49'(p1_q.dxsq) + 49'(p1_q.dysq);
    p2_d.apart   = (d2 >= 49'(p1_q.sumsq));
    p2_d.contain = !p2_d.apart && (d2 <= 49'(p1_q.diffsq));
    p2_d.d2e     = {d2[41:0], {(2*GUARD_BITS){1'b0}}};
  end

  // Center distance root, one result bit per stage
  assign sqa_in = '{rem: '0, root: '0, rad: p2_q.d2e};

  for (genvar k = 0; k < SQA_N; k++) begin : g_sqa
    sqa_t             src;
    sqa_t             nxt;
    ctx_t             csrc;
    logic [SQA_N+1:0] cand;
    logic [SQA_N+1:0] trial;

    if (k == 0) begin : g_first
      assign src  = sqa_in;
      assign csrc = p2_q;
    end else begin : g_next
      assign src  = sqa_q[k-1];
      assign csrc = sqa_c_q[k-1];
    end

    always_comb begin
      cand    = {src.rem[SQA_N-1:0], src.rad[2*SQA_N-1 -: 2]};
      trial   = {src.root, 2'b01};
      nxt.rad = {src.rad[2*SQA_N-3:0], 2'b00};
      if (cand >= trial) begin
        nxt.rem  = cand - trial;
        nxt.root = {src.root[SQA_N-2:0], 1'b1};
      end else begin
        nxt.rem  = cand;
        nxt.root = {src.root[SQA_N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sqa_q[k] <= nxt;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sqa_c_q[k] <= '0;
      end else if (adv) begin
        sqa_c_q[k] <= csrc;
      end
    end
  end

  // Stage 3: chord foot numerator
  always_comb begin
    p3_d     = sqa_c_q[SQA_N-1];
    p3_d.de  = sqa_q[SQA_N-1].root;
    p3_d.num = 60'(p3_d.d2e) + 60'({p3_d.r0sq, 16'h0000}) - 60'({p3_d.r1sq, 16'h0000});
  end

  // Stage 4: sign and magnitude
  always_comb begin
    p4_d       = p3_q;
    p4_d.qsign = p3_q.num[59];
    p4_d.mag   = p3_q.num[59] ? 59'(-p3_q.num) : p3_q.num[58:0];
  end

  // Stage 5: quotient too large for the divider width
  always_comb begin
    p5_d     = p4_q;
    p5_d.ovf = (p4_q.mag[58:29] >= {p4_q.de, 1'b0});
  end

  // Restoring divider by 2*de, one quotient bit per stage
  assign div_in = '{rem: p5_q.mag[58:29], q: '0, low: p5_q.mag[28:0]};

  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    div_t        src;
    div_t        nxt;
    ctx_t        csrc;
    logic [30:0] cand;
    logic [30:0] dv;

    if (k == 0) begin : g_first
      assign src  = div_in;
      assign csrc = p5_q;
    end else begin : g_next
      assign src  = div_q[k-1];
      assign csrc = div_c_q[k-1];
    end

    always_comb begin
      cand    = {src.rem, src.low[28]};
      dv      = {1'b0, csrc.de, 1'b0};
      nxt.low = {src.low[27:0], 1'b0};
      if (cand >= dv) begin
        nxt.rem = 30'(cand - dv);
        nxt.q   = {src.q[27:0], 1'b1};
      end else begin
        nxt.rem = cand[29:0];
        nxt.q   = {src.q[27:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[k] <= nxt;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_c_q[k] <= '0;
      end else if (adv) begin
        div_c_q[k] <= csrc;
      end
    end
  end

  // Stage 6: clamp the chord foot to the self radius
  always_comb begin
    logic [28:0] q;
    logic [27:0] r0e;
    p6_d    = div_c_q[DIV_N-1];
    q       = div_q[DIV_N-1].q;
    r0e     = {p6_d.r0, {GUARD_BITS{1'b0}}};
    p6_d.qm = (p6_d.ovf || (q > {1'b0, r0e})) ? r0e : q[27:0];
    p6_d.d0 = p6_d.qsign ? 30'd0 - {2'b00, p6_d.qm} : {2'b00, p6_d.qm};
  end

  // Stage 7: other chord foot, squared foot
  always_comb begin
    p7_d     = p6_q;
    p7_d.d1  = {2'b00, p6_q.de} - {p6_q.d0[29], p6_q.d0};
    p7_d.qsq = p6_q.qm * p6_q.qm;
  end

  // Stage 8: half-chord radicand
  always_comb begin
    p8_d      = p7_q;
    p8_d.hrad = {p7_q.r0sq, 16'h0000} - p7_q.qsq;
  end

  // Half-chord root, one result bit per stage
  assign sqb_in = '{rem: '0, root: '0, rad: p8_q.hrad};

  for (genvar k = 0; k < SQB_N; k++) begin : g_sqb
    sqb_t             src;
    sqb_t             nxt;
    ctx_t             csrc;
    logic [SQB_N+1:0] cand;
    logic [SQB_N+1:0] trial;

    if (k == 0) begin : g_first
      assign src  = sqb_in;
      assign csrc = p8_q;
    end else begin : g_next
      assign src  = sqb_q[k-1];
      assign csrc = sqb_c_q[k-1];
    end

    always_comb begin
      cand    = {src.rem[SQB_N-1:0], src.rad[2*SQB_N-1 -: 2]};
      trial   = {src.root, 2'b01};
      nxt.rad = {src.rad[2*SQB_N-3:0], 2'b00};
      if (cand >= trial) begin
        nxt.rem  = cand - trial;
        nxt.root = {src.root[SQB_N-2:0], 1'b1};
      end else begin
        nxt.rem  = cand;
        nxt.root = {src.root[SQB_N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sqb_q[k] <= nxt;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sqb_c_q[k] <= '0;
      end else if (adv) begin
        sqb_c_q[k] <= csrc;
      end
    end
  end

  // Stage 9: CORDIC operands and the chord term de*he
  always_comb begin
    logic [56:0] prod;
    p9_d      = sqb_c_q[SQB_N-1];
    p9_d.he   = sqb_q[SQB_N-1].root;
    p9_d.neg0 = p9_d.d0[29];
    p9_d.neg1 = p9_d.d1[30];
    p9_d.x0   = 31'(p9_d.neg0 ? -p9_d.d0 : p9_d.d0);
    p9_d.x1   = p9_d.neg1 ? 31'(-p9_d.d1) : p9_d.d1;
    prod      = p9_d.de * p9_d.he;
    p9_d.t    = {prod, {(ANG_BITS-2*GUARD_BITS){1'b0}}};
  end

  // Two arctangent lanes
  assign c0_in = '{x: 34'(p9_q.x0), y: 34'(p9_q.he), z: '0};
  assign c1_in = '{x: 34'(p9_q.x1), y: 34'(p9_q.he), z: '0};

  aoc_cordic u_cordic0 (
    .clk_i (clk_i),
    .en_i  (adv),
    .vec_i (c0_in),
    .vec_o (c0_out)
  );

  aoc_cordic u_cordic1 (
    .clk_i (clk_i),
    .en_i  (adv),
    .vec_i (c1_in),
    .vec_o (c1_out)
  );

  // Context delay alongside the CORDIC lanes
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cd
    ctx_t csrc;
    if (k == 0) begin : g_first
      assign csrc = p9_q;
    end else begin : g_next
      assign csrc = cd_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cd_q[k] <= '0;
      end else if (adv) begin
        cd_q[k] <= csrc;
      end
    end
  end

  // Stage 10: half angles
  always_comb begin
    p10_d    = cd_q[CORDIC_STEPS-1];
    p10_d.a0 = ang_fix(c0_out.z, p10_d.neg0);
    p10_d.a1 = ang_fix(c1_out.z, p10_d.neg1);
  end

  // Stage 11: select sector operands, partial products
  always_comb begin
    logic [39:0] opa;
    logic [39:0] opb;
    logic [21:0] anga;
    p11_d = p10_q;
    if (p10_q.contain) begin
      opa     = p10_q.msq;
      anga    = PI_Q;
      opb     = '0;
      p11_d.t = '0;
    end else if (p10_q.apart) begin
      opa     = '0;
      anga    = p10_q.a0;
      opb     = '0;
      p11_d.t = '0;
    end else begin
      opa     = p10_q.r0sq;
      anga    = p10_q.a0;
      opb     = p10_q.r1sq;
    end
    p11_d.pal = opa[19:0] * anga;
    p11_d.pah = opa[39:20] * anga;
    p11_d.pbl = opb[19:0] * p10_q.a1;
    p11_d.pbh = opb[39:20] * p10_q.a1;
  end

  // Stage 12: combine partial products
  always_comb begin
    p12_d    = p11_q;
    p12_d.sa = 64'({p11_q.pah, 20'h00000}) + 64'(p11_q.pal);
    p12_d.sb = 64'({p11_q.pbh, 20'h00000}) + 64'(p11_q.pbl);
  end

  // Stage 13: sector sum
  always_comb begin
    p13_d   = p12_q;
    p13_d.s = p12_q.sa + p12_q.sb;
  end

  // Stage 14: subtract the chord term, floor at zero
  always_comb begin
    p14_d   = p13_q;
    p14_d.s = (p13_q.s > 64'(p13_q.t)) ? p13_q.s - 64'(p13_q.t) : '0;
  end

  // Stage 15: drop the angle and fraction scaling
  always_comb begin
    p15_d      = p14_q;
    p15_d.area = p14_q.s[ANG_BITS+FRAC_BITS +: 32];
  end

  // Stage 16: weighted shares
  always_comb begin
    p16_d    = p15_q;
    p16_d.pw = wc * (p15_q.r0_gt ? p15_q.area : 32'h0);
    p16_d.pv = (W_ONE - wc) * p15_q.area[31:1];
  end

  // Output register
  always_comb begin
    logic [47:0] acc;
    out_d      = p16_q;
    acc        = p16_q.pw + 48'(p16_q.pv);
    out_d.comp = p16_q.eq_r ? {1'b0, p16_q.area[31:1]} : 32'(acc[47:15]);
  end

  // Fixed stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_q  <= '0;
      p1_q  <= '0;
      p2_q  <= '0;
      p3_q  <= '0;
      p4_q  <= '0;
      p5_q  <= '0;
      p6_q  <= '0;
      p7_q  <= '0;
      p8_q  <= '0;
      p9_q  <= '0;
      p10_q <= '0;
      p11_q <= '0;
      p12_q <= '0;
      p13_q <= '0;
      p14_q <= '0;
      p15_q <= '0;
      p16_q <= '0;
      out_q <= '0;
    end else if (adv) begin
      p0_q  <= p0_d;
      p1_q  <= p1_d;
      p2_q  <= p2_d;
      p3_q  <= p3_d;
      p4_q  <= p4_d;
      p5_q  <= p5_d;
      p6_q  <= p6_d;
      p7_q  <= p7_d;
      p8_q  <= p8_d;
      p9_q  <= p9_d;
      p10_q <= p10_d;
      p11_q <= p11_d;
      p12_q <= p12_d;
      p13_q <= p13_d;
      p14_q <= p14_d;
      p15_q <= p15_d;
      p16_q <= p16_d;
      out_q <= out_d;
    end
  end

  assign out_valid_o    = out_q.vld;
  assign overlap_area_o = out_q.area;
  assign competition_o  = out_q.comp;

  // Checks
  `AOC_ASSERT(a_comp_le_area, out_valid_o |-> (competition_o <= overlap_area_o), "competition above overlap area")
  `AOC_ASSERT(a_half_chord_range, p9_q.vld |-> (p9_q.he <= {p9_q.r0, 8'h00}), "half chord above radius")
  `AOC_ASSERT(a_angle_range, p10_q.vld |-> ((p10_q.a0 <= PI_Q) && (p10_q.a1 <= PI_Q)), "half angle above pi")
  `AOC_ASSERT_RST(a_reset_empty, !rst_ni |=> !out_valid_o, "result valid after a reset edge")

endmodule
